/* sv/sha1_pkg.sv */
// sha1_pkg: shared types and constants of the SHA-1 engine.
// Used by all modules of sha1_hash_engine_core; no dependencies.
package sha1_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_PAD, ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    BSEL_DATA, BSEL_PAD80, BSEL_ZERO, BSEL_LEN
  } byte_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic      wr_byte;
    byte_sel_e bsel;
    logic      snap_len;
    logic      comp_start;
    logic      comp_step;
    logic      comp_done;
    logic      reinit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
  } dp_stat_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [159:0] IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                 32'h10325476, 32'hC3D2E1F0};
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [2:0] LAST_IDX = 3'd4;

endpackage

/* sv/sha1_hash_engine_core.sv */
// sha1_hash_engine_core: top level of the SHA-1 engine.
// Instantiates sha1_ctrl and sha1_datapath; uses sha1_pkg.
//
// Absorb transactions are accepted one per cycle while idle; the byte completing a
// 64-byte block is followed by compression (one round per cycle), during which
// no input is accepted. A finish transaction writes the padding bytes at
// one per cycle, runs one or two compressions, then presents the five
// digest words, index 0 first, and returns to the initial state after word 4.
module sha1_hash_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sha1_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sha1_pkg::out_item_t out_data_o
);

  sha1_pkg::dp_cmd_t  cmd;
  sha1_pkg::dp_stat_t stat;
  logic [2:0]         idx;
  logic [31:0]        dig;

  sha1_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .func_i(in_data_i.func), .out_valid_o, .out_ready_i,
    .idx_o(idx), .stat_i(stat), .cmd_o(cmd)
  );

  sha1_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i(in_data_i.data_byte),
    .rd_idx_i(idx), .stat_o(stat), .digest_o(dig)
  );

  assign out_data_o.digest_word = dig;
  assign out_data_o.word_index  = idx;
  assign out_data_o.last_word   = (idx == sha1_pkg::LAST_IDX);

endmodule

/* sv/sha1_datapath.sv */
// sha1_datapath: block buffer as 16 words, bit counter, chaining words and
// a one-round-per-cycle compression unit. Depends on sha1_pkg.
module sha1_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [2:0]        rd_idx_i,
  output sha1_pkg::dp_stat_t stat_o,
  output logic [31:0]       digest_o
);

  logic [63:0]  cnt_q, cnt_d;
  logic [63:0]  len_q;
  logic [159:0] h_q, h_d;
  logic [31:0]  w_q [16];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [6:0]   rnd_q;
  logic [7:0]   byte_v;
  logic [5:0]   pos;
  logic [31:0]  wnew, m, f, k, t;

  assign pos = cnt_q[8:3];

  always_comb begin
    case (cmd_i.bsel)
      sha1_pkg::BSEL_DATA:  byte_v = data_byte_i;
      sha1_pkg::BSEL_PAD80: byte_v = 8'h80;
      sha1_pkg::BSEL_ZERO:  byte_v = 8'h00;
      sha1_pkg::BSEL_LEN:   byte_v = len_q[8'd63 - {2'd0, pos[2:0], 3'd0} -: 8];
      default:              byte_v = 8'h00;
    endcase
  end

  // schedule: w_q[0] is the word of rounds 0-15; window shifts each round
  assign wnew = (rnd_q < 7'd16) ? w_q[0] :
                {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                 w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign m = wnew;

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = sha1_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = sha1_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sha1_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = sha1_pkg::K3;
    end
  end
  assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + m;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.wr_byte) cnt_d = cnt_q + 64'd8;
    if (cmd_i.reinit) cnt_d = '0;
  end

  // comp_done comes with the last round, so fold in that round's result
  always_comb begin
    h_d = h_q;
    if (cmd_i.comp_done)
      h_d = {h_q[159:128] + t, h_q[127:96] + a_q,
             h_q[95:64] + {b_q[1:0], b_q[31:2]},
             h_q[63:32] + c_q, h_q[31:0] + d_q};
    if (cmd_i.reinit) h_d = sha1_pkg::IV;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      h_q   <= sha1_pkg::IV;
      rnd_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      h_q   <= h_d;
      if (cmd_i.comp_start) rnd_q <= '0;
      else if (cmd_i.comp_step) rnd_q <= rnd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap_len) len_q <= cnt_q;
    if (cmd_i.wr_byte) w_q[pos[5:2]][8'd31 - {3'd0, pos[1:0], 3'd0} -: 8] <= byte_v;
    if (cmd_i.comp_start) begin
      {a_q, b_q, c_q, d_q, e_q} <= h_q;
    end else if (cmd_i.comp_step) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wnew;
    end
  end

  assign stat_o.pos        = pos;
  assign stat_o.round_last = (rnd_q == 7'd79);
  assign digest_o = h_q[8'd159 - {rd_idx_i, 5'd0} -: 32];

endmodule

/* sv/sha1_ctrl.sv */
// sha1_ctrl: controller state machine sequencing absorb, compression,
// padding and digest output. Depends on sha1_pkg.
module sha1_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         idx_o,
  input  sha1_pkg::dp_stat_t stat_i,
  output sha1_pkg::dp_cmd_t  cmd_o
);

  sha1_pkg::state_e state_q, state_d;
  logic             fin_q, fin_d;   // compression belongs to padding
  logic [2:0]       idx_q, idx_d;
  logic             acc, pad_wr, emit_go;
  logic             pad_done_q, pad_done_d;
  logic             len_phase_q, len_phase_d;
  logic             pad80_q, pad80_d;

  assign acc = in_valid_i && in_ready_o;
  assign pad_wr = (state_q == sha1_pkg::ST_PAD);
  assign emit_go = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (acc) begin
          fin_d = func_i;
          if (func_i) state_d = sha1_pkg::ST_PAD;
          else if (stat_i.pos == 6'd63) state_d = sha1_pkg::ST_COMP;
        end
      end
      sha1_pkg::ST_COMP: begin
        if (stat_i.round_last)
          state_d = fin_q ? (pad_done_q ? sha1_pkg::ST_EMIT : sha1_pkg::ST_PAD)
                          : sha1_pkg::ST_IDLE;
      end
      sha1_pkg::ST_PAD: begin
        if (stat_i.pos == 6'd63) state_d = sha1_pkg::ST_COMP;
      end
      sha1_pkg::ST_EMIT: begin
        if (emit_go) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == sha1_pkg::LAST_IDX) begin
            idx_d = '0;
            state_d = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  // pad_done: length bytes were written in the current padding run
  always_comb begin
    pad_done_d = pad_done_q;
    if (acc) pad_done_d = 1'b0;
    if (pad_wr && stat_i.pos == 6'd63 && len_phase_q) pad_done_d = 1'b1;
  end

  // len_phase: the current padding block carries the length field
  always_comb begin
    len_phase_d = len_phase_q;
    pad80_d     = pad80_q;
    if (acc) begin
      pad80_d     = 1'b0;
      // 0x80 lands at pos; length fits if pos < 56
      len_phase_d = (stat_i.pos < sha1_pkg::LEN_POS);
    end
    if (pad_wr) pad80_d = 1'b1;
    if (state_q == sha1_pkg::ST_COMP && stat_i.round_last && fin_q) len_phase_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1_pkg::ST_IDLE;
      fin_q       <= 1'b0;
      idx_q       <= '0;
      pad_done_q  <= 1'b0;
      len_phase_q <= 1'b0;
      pad80_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      idx_q       <= idx_d;
      pad_done_q  <= pad_done_d;
      len_phase_q <= len_phase_d;
      pad80_q     <= pad80_d;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.bsel = sha1_pkg::BSEL_DATA;
    in_ready_o  = (state_q == sha1_pkg::ST_IDLE);
    out_valid_o = (state_q == sha1_pkg::ST_EMIT);
    case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (acc && !func_i) cmd_o.wr_byte = 1'b1;
        if (acc && func_i) cmd_o.snap_len = 1'b1;
        if (acc && !func_i && stat_i.pos == 6'd63) cmd_o.comp_start = 1'b1;
      end
      sha1_pkg::ST_COMP: begin
        cmd_o.comp_step = 1'b1;
        cmd_o.comp_done = stat_i.round_last;
      end
      sha1_pkg::ST_PAD: begin
        cmd_o.wr_byte = 1'b1;
        if (!pad80_q) cmd_o.bsel = sha1_pkg::BSEL_PAD80;
        else if (len_phase_q && stat_i.pos >= sha1_pkg::LEN_POS)
          cmd_o.bsel = sha1_pkg::BSEL_LEN;
        else cmd_o.bsel = sha1_pkg::BSEL_ZERO;
        if (stat_i.pos == 6'd63) cmd_o.comp_start = 1'b1;
      end
      sha1_pkg::ST_EMIT: begin
        if (emit_go && idx_q == sha1_pkg::LAST_IDX) cmd_o.reinit = 1'b1;
      end
      default: ;
    endcase
  end

  assign idx_o = idx_q;

endmodule

/* sv/sha1_checker.sv */
// sha1_checker: port-level assertions for sha1_hash_engine_core, bound below.
// Uses sha1_pkg.
module sha1_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sha1_pkg::out_item_t out_data_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken during output");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word ==
                     (out_data_o.word_index == sha1_pkg::LAST_IDX)))
    else $error("last_word mismatch");

  a_idx_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
    (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("word index did not advance");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output changed while stalled");

endmodule

bind sha1_hash_engine_core sha1_checker u_chk (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
